/* rtl/core/dda_pkg.sv */
// shared types and constants for the dda line rasterizer
package dda_pkg;

  localparam int SCREEN_WIDTH_DEF = 640;

  localparam int XW    = 10;
  localparam int YW    = 9;
  localparam int COLW  = 8;
  localparam int ADDRW = 19;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef struct packed {
    logic [ADDRW-1:0] address;
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic [COLW-1:0]  color;
    logic             last;
  } pixel_t;

  // status from the line walker to the top level
  typedef struct packed {
    logic busy;
    logic last_now;
  } walk_status_t;

endpackage

/* rtl/core/dda_walk.sv */
// line setup, step state and pixel computation for the dda rasterizer
module dda_walk #(
  parameter int SCREEN_WIDTH = dda_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic                       advance,
  input  logic [dda_pkg::XW-1:0]     x_a,
  input  logic [dda_pkg::YW-1:0]     y_a,
  input  logic [dda_pkg::XW-1:0]     x_b,
  input  logic [dda_pkg::YW-1:0]     y_b,
  input  logic [dda_pkg::COLW-1:0]   color,
  output dda_pkg::pixel_t            pix,
  output dda_pkg::walk_status_t      status
);
  import dda_pkg::*;

  localparam int ProdW = YW + $clog2(SCREEN_WIDTH + 1) + 1;
  localparam int SumW  = (ProdW > ADDRW) ? ProdW : ADDRW;

  logic            busy;
  logic            major_is_y;
  logic            minor_descends;
  logic [XW-1:0]   step_index;
  logic [XW-1:0]   major_length;
  logic [XW-1:0]   minor_length;
  logic [XW-1:0]   origin_x;
  logic [YW-1:0]   origin_y;
  logic [YW-1:0]   far_y;
  logic [XW-1:0]   minor_offset;
  logic [XW-1:0]   remainder_acc;
  logic [COLW-1:0] line_color;

  // load setup
  logic            swap_x, swap_y;
  logic [XW-1:0]   xmin, xmax, dx;
  logic [YW-1:0]   ymin, ymax, dy;
  logic            ld_major_is_y;
  logic [XW-1:0]   ld_major, ld_minor;

  // step
  logic            is_last;
  logic [XW-1:0]   px;
  logic [YW-1:0]   py;
  logic [YW-1:0]   up;
  logic [XW:0]     rem_sum;
  logic            rem_wrap;
  logic [XW-1:0]   remainder_acc_next;
  logic [XW-1:0]   minor_offset_next;
  logic [SumW-1:0] addr_full;

  always_comb begin
    swap_x        = x_a > x_b;
    swap_y        = y_a > y_b;
    xmin          = swap_x ? x_b : x_a;
    xmax          = swap_x ? x_a : x_b;
    ymin          = swap_y ? y_b : y_a;
    ymax          = swap_y ? y_a : y_b;
    dx            = xmax - xmin;
    dy            = ymax - ymin;
    ld_major_is_y = {1'b0, dy} > dx;
    ld_major      = ld_major_is_y ? {1'b0, dy} : dx;
    ld_minor      = ld_major_is_y ? dx : {1'b0, dy};
  end

  always_comb begin
    is_last = step_index == major_length;
    up      = minor_offset[YW-1:0] + YW'(remainder_acc != '0);
    if (major_is_y) begin
      px = origin_x + minor_offset;
      py = minor_descends ? far_y - step_index[YW-1:0] : origin_y + step_index[YW-1:0];
    end else begin
      px = origin_x + step_index;
      // descending minor uses the ceiling of the exact offset
      py = minor_descends ? far_y - up : origin_y + minor_offset[YW-1:0];
    end
    rem_sum  = {1'b0, remainder_acc} + {1'b0, minor_length};
    rem_wrap = rem_sum >= {1'b0, major_length};
    remainder_acc_next = rem_wrap ? XW'(rem_sum - {1'b0, major_length}) : rem_sum[XW-1:0];
    minor_offset_next  = rem_wrap ? minor_offset + 1'b1 : minor_offset;
    addr_full = SumW'(py) * SumW'(SCREEN_WIDTH) + SumW'(px);
  end

  assign pix.address     = addr_full[ADDRW-1:0];
  assign pix.x           = px;
  assign pix.y           = py;
  assign pix.color       = line_color;
  assign pix.last        = is_last;
  assign status.busy     = busy;
  assign status.last_now = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (advance && busy && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      major_is_y     <= ld_major_is_y;
      minor_descends <= swap_x != swap_y;
      major_length   <= ld_major;
      minor_length   <= ld_minor;
      origin_x       <= xmin;
      origin_y       <= ymin;
      far_y          <= ymax;
      step_index     <= '0;
      minor_offset   <= '0;
      remainder_acc  <= '0;
      line_color     <= color;
    end else if (advance && busy && !is_last) begin
      remainder_acc <= remainder_acc_next;
      minor_offset  <= minor_offset_next;
      step_index    <= step_index + 1'b1;
    end
  end

endmodule

/* rtl/core/dda_line_rasterizer.sv */
// top level of the dda line rasterizer with output skid stage
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    mode, x_a, y_a, x_b, y_b, color
//  out      output     out_valid / out_stall  pixel_address, pixel_x, pixel_y,
//                                             pixel_color, last
//
// one request per clock while in_stall is low; a pixel request is registered
// into out unless out is stalled. the line walker updates its step state as
// each request is taken, the pixel multiply-add ahead of the output register.
// a line of major length n yields n+1 pixels over n+1 pixel requests.
// reset clears busy and both output slots; no clearing pass.
// a two-entry output stage lets in keep flowing while out is stalled;
// in_stall is high only when both slots are full.
module dda_line_rasterizer #(
  parameter int SCREEN_WIDTH = dda_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       mode,
  input  logic [dda_pkg::XW-1:0]     x_a,
  input  logic [dda_pkg::YW-1:0]     y_a,
  input  logic [dda_pkg::XW-1:0]     x_b,
  input  logic [dda_pkg::YW-1:0]     y_b,
  input  logic [dda_pkg::COLW-1:0]   color,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dda_pkg::ADDRW-1:0]  pixel_address,
  output logic [dda_pkg::XW-1:0]     pixel_x,
  output logic [dda_pkg::YW-1:0]     pixel_y,
  output logic [dda_pkg::COLW-1:0]   pixel_color,
  output logic                       last
);
  import dda_pkg::*;

  logic         in_fire;
  logic         load;
  logic         advance;
  logic         gen;
  logic         out_free;
  pixel_t       pix;
  walk_status_t status;
  pixel_t       out_pix;
  pixel_t       skid_pix;
  logic         skid_valid;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign load     = in_fire && (mode == MODE_LOAD);
  assign advance  = in_fire && (mode == MODE_PIXEL);
  assign gen      = advance && status.busy;
  assign out_free = !out_valid || !out_stall;

  dda_walk #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_walk (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .advance(advance),
    .x_a    (x_a),
    .y_a    (y_a),
    .x_b    (x_b),
    .y_b    (y_b),
    .color  (color),
    .pix    (pix),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= gen;
      end
    end else if (gen) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_pix <= skid_valid ? skid_pix : pix;
    end
    if (!out_free && gen) begin
      skid_pix <= pix;
    end
  end

  assign pixel_address = out_pix.address;
  assign pixel_x       = out_pix.x;
  assign pixel_y       = out_pix.y;
  assign pixel_color   = out_pix.color;
  assign last          = out_pix.last;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output slot empty");

  a_load_sets_busy: assert property (@(posedge clk) disable iff (rst)
    load |=> status.busy)
    else $error("line load did not start a walk");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (gen && status.last_now) |=> !status.busy)
    else $error("walk still busy after final pixel");
`endif

endmodule
